// ----- rtl/s512_pkg.sv -----
// SHA-512 stream hasher package: payload and control types, state codes,
// initial chaining value, round constants and round functions. No dependencies.
`timescale 1ns / 1ps
package s512_pkg;

   localparam int BufDepth = 16;
   localparam int AddrW    = 4;

   typedef logic [63:0]      word_type;
   typedef logic [AddrW-1:0] addr_type;
   typedef word_type [7:0]   chain_type;

   typedef struct packed {
      logic [63:0] msg_word;
      logic [3:0]  byte_count;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic        digest_last;
   } rsp_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } buf_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ZERO,
      ST_LEN,
      ST_LEN2,
      ST_COMP,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      RET_IDLE,
      RET_PAD,
      RET_ZERO,
      RET_OUT
   } ret_type;

   localparam addr_type LastIdx  = 4'd15;
   localparam addr_type LenHiIdx = 4'd14;
   localparam addr_type PreLenIdx = 4'd13;
   localparam logic [7:0] PadByte = 8'h80;

   localparam chain_type InitChain = {
      64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
      64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
      64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
      64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
   };

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type big_s0(input word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_s1(input word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_s0(input word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_s1(input word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type round_k(input logic [6:0] idx);
      word_type k;
      case (idx)
         7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
         7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
         7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
         7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
         7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/s512_core.sv -----
// SHA-512 compression core: 16-word block memory holding the message schedule
// window, one round per cycle. Depends on s512_pkg.
`timescale 1ns / 1ps
module s512_core (
   input  logic                  clock,
   input  logic                  reset,
   input  s512_pkg::buf_wr_type  buf_wr,
   input  logic                  start,
   input  s512_pkg::chain_type   chain_i,
   output logic                  done,
   output s512_pkg::chain_type   chain_o
);
   import s512_pkg::*;

   localparam logic [6:0] LastStep = 7'd80;
   localparam logic [6:0] DoneCnt  = 7'd82;
   localparam logic [6:0] MsgSteps = 7'd16;

   word_type  mem [BufDepth];
   word_type  rda_ff, rdb_ff;
   addr_type  rda_addr, rdb_addr;
   logic      busy_ff, busy_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [6:0] step;
   logic [6:0] rnd;
   word_type  wt_ff, wt_in;
   word_type  hist_ff [7];
   chain_type v_ff, v_in;
   word_type  t1, t2;
   logic      sched_en, round_en;
   buf_wr_type wr;

   assign step     = cnt_ff - 7'd1;
   assign rnd      = cnt_ff - 7'd2;
   assign sched_en = busy_ff && (cnt_ff >= 7'd1) && (cnt_ff <= LastStep);
   assign round_en = busy_ff && (cnt_ff >= 7'd2) && (cnt_ff < DoneCnt);
   assign rda_addr = cnt_ff[AddrW-1:0];
   assign rdb_addr = cnt_ff[AddrW-1:0] + addr_type'(1);
   assign done     = busy_ff && (cnt_ff == DoneCnt);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = 7'd1;
         end
      end else if (cnt_ff == DoneCnt) begin
         busy_in = 1'b0;
         cnt_in  = '0;
      end else begin
         cnt_in = cnt_ff + 7'd1;
      end
   end

   always_comb begin
      if (step < MsgSteps) begin
         wt_in = rda_ff;
      end else begin
         wt_in = small_s1(hist_ff[1]) + hist_ff[6] + small_s0(rdb_ff) + rda_ff;
      end
      wr = buf_wr;
      if (sched_en && step >= MsgSteps) begin
         wr.en   = 1'b1;
         wr.addr = step[AddrW-1:0];
         wr.data = wt_in;
      end
   end

   always_comb begin
      t1 = v_ff[7] + big_s1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + round_k(rnd) + wt_ff;
      t2 = big_s0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in    = v_ff;
      v_in[0] = t1 + t2;
      v_in[1] = v_ff[0];
      v_in[2] = v_ff[1];
      v_in[3] = v_ff[2];
      v_in[4] = v_ff[3] + t1;
      v_in[5] = v_ff[4];
      v_in[6] = v_ff[5];
      v_in[7] = v_ff[6];
      for (int i = 0; i < 8; i++) begin
         chain_o[i] = chain_i[i] + v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rda_ff <= mem[rda_addr];
      rdb_ff <= mem[rdb_addr];
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && start) begin
         v_ff <= chain_i;
      end else if (round_en) begin
         v_ff <= v_in;
      end
      if (sched_en) begin
         wt_ff      <= wt_in;
         hist_ff[0] <= wt_in;
         for (int i = 1; i < 7; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ----- rtl/sha512_stream_hasher.sv -----
// SHA-512 stream hasher top level: byte packing, padding sequencer, digest output.
// Depends on s512_pkg and s512_core.
// A word that does not complete a block is taken while idle; a word that
// completes a block starts a compression (one round per cycle).
// A final word adds the padding states (PAD, ZERO, LEN, LEN2), one or two compressions
// and then the eight digest words, one per accepted transaction.
// Reset returns the chaining value, fill count and bit length to their initial values.
`timescale 1ns / 1ps
module sha512_stream_hasher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  s512_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output s512_pkg::rsp_type rsp_payload
);
   import s512_pkg::*;

   state_type   state_ff, state_in;
   ret_type     ret_ff, ret_in;
   logic [6:0]  fill_ff, fill_in;
   word_type    bitlen_ff, bitlen_in;
   word_type    acc_ff, acc_in;
   chain_type   chain_ff, chain_in;
   logic [2:0]  ocnt_ff, ocnt_in;

   buf_wr_type  buf_wr;
   logic        start;
   logic        done;
   chain_type   chain_sum;

   logic [3:0]   n;
   logic [2:0]   off;
   addr_type     idx;
   logic [3:0]   tot;
   word_type     mask;
   logic [127:0] win;
   word_type     mark;

   s512_core u_core (
      .clock   (clock),
      .reset   (reset),
      .buf_wr  (buf_wr),
      .start   (start),
      .chain_i (chain_ff),
      .done    (done),
      .chain_o (chain_sum)
   );

   always_comb begin
      n    = (req_payload.byte_count > 4'd8) ? 4'd8 : req_payload.byte_count;
      off  = fill_ff[2:0];
      idx  = fill_ff[6:3];
      tot  = {1'b0, off} + n;
      mask = ~({64{1'b1}} >> {n, 3'b000});
      win  = {acc_ff, 64'b0} | ({req_payload.msg_word & mask, 64'b0} >> {off, 3'b000});
      mark = {PadByte, 56'b0} >> {off, 3'b000};
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fill_in   = fill_ff;
      bitlen_in = bitlen_ff;
      acc_in    = acc_ff;
      chain_in  = chain_ff;
      ocnt_in   = ocnt_ff;
      buf_wr    = '0;
      start     = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      rsp_payload.digest_word = chain_ff[ocnt_ff];
      rsp_payload.digest_last = (ocnt_ff == 3'd7);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fill_in   = fill_ff + 7'(n);
               bitlen_in = bitlen_ff + {57'b0, n, 3'b000};
               if (tot[3]) begin
                  buf_wr = '{en: 1'b1, addr: idx, data: win[127:64]};
                  acc_in = win[63:0];
               end else begin
                  acc_in = win[127:64];
               end
               if (tot[3] && idx == LastIdx) begin
                  start    = 1'b1;
                  state_in = ST_COMP;
                  ret_in   = req_payload.final_word ? RET_PAD : RET_IDLE;
               end else if (req_payload.final_word) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            buf_wr  = '{en: 1'b1, addr: idx, data: acc_ff | mark};
            acc_in  = '0;
            fill_in = {idx + addr_type'(1), 3'b000};
            if (idx == LastIdx) begin
               start    = 1'b1;
               state_in = ST_COMP;
               ret_in   = RET_ZERO;
            end else if (idx == PreLenIdx) begin
               state_in = ST_LEN;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            buf_wr  = '{en: 1'b1, addr: idx, data: '0};
            fill_in = {idx + addr_type'(1), 3'b000};
            if (idx == LastIdx) begin
               start    = 1'b1;
               state_in = ST_COMP;
               ret_in   = RET_ZERO;
            end else if (idx == PreLenIdx) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            buf_wr   = '{en: 1'b1, addr: LenHiIdx, data: '0};
            state_in = ST_LEN2;
         end
         ST_LEN2: begin
            buf_wr   = '{en: 1'b1, addr: LastIdx, data: bitlen_ff};
            start    = 1'b1;
            state_in = ST_COMP;
            ret_in   = RET_OUT;
         end
         ST_COMP: begin
            if (done) begin
               chain_in = chain_sum;
               unique case (ret_ff)
                  RET_IDLE: state_in = ST_IDLE;
                  RET_PAD:  state_in = ST_PAD;
                  RET_ZERO: state_in = ST_ZERO;
                  RET_OUT:  state_in = ST_OUT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               ocnt_in = ocnt_ff + 3'd1;
               if (ocnt_ff == 3'd7) begin
                  chain_in  = InitChain;
                  fill_in   = '0;
                  bitlen_in = '0;
                  acc_in    = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= RET_IDLE;
         fill_ff   <= '0;
         bitlen_ff <= '0;
         acc_ff    <= '0;
         chain_ff  <= InitChain;
         ocnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
         acc_ff    <= acc_in;
         chain_ff  <= chain_in;
         ocnt_ff   <= ocnt_in;
      end
   end

endmodule

// ----- rtl/s512_checker.sv -----
// Port-level checker for the SHA-512 stream hasher, bound to the top level.
// Depends on s512_pkg.
`timescale 1ns / 1ps
module s512_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input s512_pkg::rsp_type rsp_payload
);

   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while digest pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.digest_last |=> !rsp_valid && !req_stall)
      else $error("digest did not end after last word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind sha512_stream_hasher s512_checker u_s512_checker (.*);

// ----- tb/sha512_stream_hasher_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sha512_stream_hasher: random messages are hashed by an
// in-bench SHA-512 predictor and compared word by word. Depends on s512_pkg.
module sha512_stream_hasher_test;
   import s512_pkg::*;

   localparam int CycleLimit = 600000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   sha512_stream_hasher u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   localparam logic [63:0] HashInit [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   localparam logic [63:0] RoundConst [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   logic [63:0] hash_state [8];
   logic [7:0]  block_bytes [128];
   int          block_fill;
   logic [63:0] msg_bits;

   req_type pending_words [$];
   rsp_type digest_words [$];
   int      mismatches = 0;
   int      cycle_count = 0;
   bit      req_taken = 1'b0;
   bit      rsp_taken = 1'b0;
   bit      busy_mode = 1'b0;
   int      req_gap = 0;
   int      rsp_hold = 0;
   int      words_sent = 0;

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   task automatic compress_block();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] t1, t2;
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 8; j++) w[i][63-8*j -: 8] = block_bytes[8*i+j];
      end
      for (int i = 16; i < 80; i++) begin
         w[i] = (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
              + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 80; i++) begin
         t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
         t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      block_bytes[block_fill] = b;
      block_fill++;
      if (block_fill == 128) begin
         compress_block();
         block_fill = 0;
      end
   endtask

   task automatic start_message();
      for (int i = 0; i < 8; i++) hash_state[i] = HashInit[i];
      block_fill = 0;
      msg_bits = '0;
   endtask

   task automatic hash_word(input req_type r);
      int n;
      rsp_type d;
      n = (r.byte_count > 8) ? 8 : int'(r.byte_count);
      for (int i = 0; i < n; i++) begin
         absorb_byte(r.msg_word[63-8*i -: 8]);
         msg_bits = msg_bits + 64'd8;
      end
      if (r.final_word) begin
         absorb_byte(8'h80);
         while (block_fill != 112) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(msg_bits[63-8*i -: 8]);
         for (int k = 0; k < 8; k++) begin
            d.digest_word = hash_state[k];
            d.digest_last = (k == 7);
            digest_words.push_back(d);
         end
         start_message();
      end
   endtask

   function automatic req_type make_word(input logic [63:0] m, input int c, input bit f);
      req_type r;
      r.msg_word = m;
      r.byte_count = c[3:0];
      r.final_word = f;
      return r;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   initial start_message();

   // stimulus
   initial begin
      int nwords;
      pending_words.push_back(make_word('0, 0, 1'b1));
      pending_words.push_back(make_word('1, 8, 1'b1));
      pending_words.push_back(make_word('0, 8, 1'b1));
      pending_words.push_back(make_word(rand_word(), 0, 1'b0));
      pending_words.push_back(make_word(rand_word(), 9, 1'b0));
      pending_words.push_back(make_word('1, 15, 1'b0));
      pending_words.push_back(make_word(rand_word(), 3, 1'b1));
      pending_words.push_back(make_word(rand_word(), 1, 1'b0));
      pending_words.push_back(make_word(rand_word(), 0, 1'b1));
      pending_words.push_back(make_word('1, 12, 1'b0));
      pending_words.push_back(make_word(rand_word(), 7, 1'b1));
      while (pending_words.size() < 450) begin
         nwords = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 34)
                                              : $urandom_range(0, 11);
         for (int i = 0; i < nwords; i++) begin
            if ($urandom_range(0, 7) == 0)
               pending_words.push_back(make_word(rand_word(), $urandom_range(0, 15), 1'b0));
            else
               pending_words.push_back(make_word(rand_word(), 8, 1'b0));
         end
         pending_words.push_back(make_word(rand_word(), $urandom_range(0, 15), 1'b1));
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || digest_words.size() != 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_payload <= pending_words.pop_front();
            req_valid <= 1'b1;
            words_sent <= words_sent + 1;
            if (words_sent % 40 == 0) busy_mode <= ~busy_mode;
            req_gap <= busy_mode ? 0 : $urandom_range(0, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result-side stall
   always @(negedge clock) begin
      int wait_cycles;
      if (rsp_taken) begin
         wait_cycles = busy_mode ? 0 : $urandom_range(0, 17);
         rsp_hold <= (wait_cycles > 0) ? wait_cycles - 1 : 0;
         rsp_stall <= (wait_cycles > 0);
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= req_valid && !req_stall && !reset;
      rsp_taken <= rsp_valid && !rsp_stall && !reset;
      if (!reset && req_valid && !req_stall) hash_word(req_payload);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: word %h last %b",
                        rsp_payload.digest_word, rsp_payload.digest_last);
         end else begin
            want = digest_words.pop_front();
            if (rsp_payload.digest_word !== want.digest_word ||
                rsp_payload.digest_last !== want.digest_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("digest mismatch: expected %h/%b actual %h/%b",
                           want.digest_word, want.digest_last,
                           rsp_payload.digest_word, rsp_payload.digest_last);
            end
         end
      end
   end
endmodule
